### hw/rtl/tiny_register_machine_execute_top_defines.svh
// assertion macros for the register machine execute block
`ifndef TINY_REGISTER_MACHINE_EXECUTE_TOP_DEFINES_SVH
`define TINY_REGISTER_MACHINE_EXECUTE_TOP_DEFINES_SVH
`ifndef SYNTH
`define TRM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define TRM_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TRM_ASSERT(lbl, clk, rstn, prop, msg)
`define TRM_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

### hw/rtl/trm_pkg.sv
`timescale 1ns / 1ps
package trm_pkg;
  localparam int unsigned NumRegs  = 16;
  localparam int unsigned MemWords = 512;
  localparam int unsigned DataW    = 32;
  localparam int unsigned RegIdxW  = 5;
  localparam int unsigned MemAddrW = 9;
  localparam int unsigned CntW     = 6;

  typedef enum logic [3:0] {
    OP_SET = 4'd0, OP_PUT = 4'd1, OP_LPC = 4'd2, OP_ADD = 4'd3,
    OP_SUB = 4'd4, OP_MUL = 4'd5, OP_DIV = 4'd6, OP_DUMP = 4'd7,
    OP_FDUMP = 4'd8, OP_MW = 4'd9, OP_MR = 4'd10
  } op_e;

  typedef enum logic [1:0] {
    KIND_ACK = 2'd0, KIND_CHAR = 2'd1, KIND_DEC = 2'd2, KIND_DUMP = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_OK = 2'd0, ERR_DIV0 = 2'd1, ERR_BADREG = 2'd2, ERR_BADOP = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    SER_MUL = 2'd0, SER_DIV = 2'd1
  } ser_op_e;

  // start request to the bit-serial unit
  typedef struct packed {
    logic                start;
    ser_op_e             op;
    logic [DataW-1:0]    a;
    logic [DataW-1:0]    b;
  } ser_req_t;

  typedef struct packed {
    logic                done;
    logic [DataW-1:0]    res;
  } ser_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_SER, ST_OUT, ST_DUMP
  } state_e;
endpackage

### hw/rtl/trm_serial_alu.sv
`timescale 1ns / 1ps
// one bit per cycle shift-add multiply and restoring divide
module trm_serial_alu
  import trm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  ser_req_t req_i,
  output ser_rsp_t rsp_o
);
  logic             busy_q, busy_d;
  ser_op_e          op_q, op_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DataW-1:0] acc_q, acc_d;   // product or remainder
  logic [DataW-1:0] sh_q, sh_d;     // multiplier or dividend/quotient
  logic [DataW-1:0] b_q, b_d;       // multiplicand or divisor magnitude
  logic             neg_q, neg_d;
  logic [DataW:0]   trial;
  logic [DataW-1:0] rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    acc_q <= acc_d;
    sh_q  <= sh_d;
    b_q   <= b_d;
    neg_q <= neg_d;
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    op_d   = op_q;
    acc_d  = acc_q;
    sh_d   = sh_q;
    b_d    = b_q;
    neg_d  = neg_q;
    rem_sh = {acc_q[DataW-2:0], sh_q[DataW-1]};
    trial  = {1'b0, rem_sh} - {1'b0, b_q};
    rsp_o.done = 1'b0;
    rsp_o.res  = neg_q ? (~sh_q + 1'b1) : sh_q;
    if (op_q == SER_MUL) rsp_o.res = acc_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      op_d   = req_i.op;
      acc_d  = '0;
      if (req_i.op == SER_MUL) begin
        sh_d  = req_i.b;
        b_d   = req_i.a;
        neg_d = 1'b0;
      end else begin
        sh_d  = req_i.a[DataW-1] ? ~req_i.a + 1'b1 : req_i.a;
        b_d   = req_i.b[DataW-1] ? ~req_i.b + 1'b1 : req_i.b;
        neg_d = req_i.a[DataW-1] ^ req_i.b[DataW-1];
      end
    end else if (busy_q) begin
      if (cnt_q == CntW'(DataW)) begin
        busy_d     = 1'b0;
        rsp_o.done = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
        if (op_q == SER_MUL) begin
          // lsb first: add shifted multiplicand
          if (sh_q[0]) acc_d = acc_q + b_q;
          sh_d = sh_q >> 1;
          b_d  = b_q << 1;
        end else begin
          if (!trial[DataW]) begin
            acc_d = trial[DataW-1:0];
            sh_d  = {sh_q[DataW-2:0], 1'b1};
          end else begin
            acc_d = rem_sh;
            sh_d  = {sh_q[DataW-2:0], 1'b0};
          end
        end
      end
    end
  end
endmodule

### hw/rtl/tiny_register_machine_execute_top.sv
`timescale 1ns / 1ps
// channel | dir | tdata fields (lsb up)                           | tuser
// s_axis  | in  | mode[3:0] reg_index[8:4] mem_address[17:9] imm[49:18] | -
// m_axis  | out | out_value[31:0] out_register[36:32]            | kind[1:0] error[3:2]; tlast last
// flow: each accepted word passes ST_READ and ST_EXEC; the result word is loaded into the output register
// in ST_EXEC, and the next word is accepted after it is taken; mul and div wait in ST_SER for the bit-serial unit
// fdump 17 output words, one per cycle when the sink is ready
// reset clears registers by valid bits and memory by a clearing pass over all 512 words
// during the clearing pass s_axis_tready is low
// one word in flight at a time; output stalls hold the word in the output register
`include "tiny_register_machine_execute_top_defines.svh"
module tiny_register_machine_execute_top
  import trm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // mode, reg_index, mem_address, immediate
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // out_value, out_register
  output logic [3:0]  m_axis_tuser,  // out_kind, error_code
  output logic        m_axis_tlast   // last
);
  state_e               st_q, st_d;
  logic [DataW-1:0]     regs_q [NumRegs+1];
  logic [NumRegs:0]     rvalid_q;
  logic [DataW-1:0]     mem_q [MemWords];
  logic [DataW-1:0]     mrd_q;
  logic [MemAddrW:0]    clr_q;
  logic [DataW-1:0]     pc_q;
  logic [3:0]           op_q;
  logic [RegIdxW-1:0]   ri_q;
  logic [MemAddrW-1:0]  ma_q;
  logic [DataW-1:0]     imm_q;
  logic [DataW-1:0]     rv;
  logic [RegIdxW-1:0]   dcnt_q, dcnt_d;
  logic                 ov_q, ol_q;
  logic [DataW-1:0]     oval_q;
  logic [RegIdxW-1:0]   oreg_q;
  logic [1:0]           okind_q, oerr_q;
  logic                 load_o;
  logic [1:0]           nkind, nerr;
  logic [DataW-1:0]     nval;
  logic [RegIdxW-1:0]   nreg;
  logic                 nlast;
  logic                 wr_en;
  logic [DataW-1:0]     wr_val;
  logic                 mem_we;
  ser_req_t             sreq;
  ser_rsp_t             srsp;
  logic                 clearing;
  logic [RegIdxW-1:0]   dreg;

  assign clearing = !clr_q[MemAddrW];
  assign s_axis_tready = (st_q == ST_IDLE) && !clearing;
  assign rv = rvalid_q[ri_q] ? regs_q[ri_q] : '0;
  // dump order: data register first, then general registers upward
  assign dreg = (dcnt_q == '0) ? RegIdxW'(NumRegs) : dcnt_q - 1'b1;

  trm_serial_alu u_alu (.clk_i, .rst_ni, .req_i(sreq), .rsp_o(srsp));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      rvalid_q <= '0;
      clr_q    <= '0;
      pc_q     <= '0;
      dcnt_q   <= '0;
      ov_q     <= 1'b0;
    end else begin
      st_q   <= st_d;
      dcnt_q <= dcnt_d;
      if (clearing) clr_q <= clr_q + 1'b1;
      if (s_axis_tvalid && s_axis_tready) pc_q <= pc_q + 1'b1;
      if (wr_en) rvalid_q[ri_q] <= 1'b1;
      if (load_o) ov_q <= 1'b1;
      else if (m_axis_tready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q  <= s_axis_tdata[3:0];
      ri_q  <= s_axis_tdata[8:4];
      ma_q  <= s_axis_tdata[17:9];
      imm_q <= s_axis_tdata[49:18];
    end
    if (wr_en) regs_q[ri_q] <= wr_val;
    if (clearing) mem_q[clr_q[MemAddrW-1:0]] <= '0;
    else if (mem_we) mem_q[ma_q] <= rv;
    mrd_q <= mem_q[ma_q];
    if (load_o) begin
      oval_q  <= nval;
      oreg_q  <= nreg;
      okind_q <= nkind;
      oerr_q  <= nerr;
      ol_q    <= nlast;
    end
  end

  always_comb begin
    st_d   = st_q;
    dcnt_d = dcnt_q;
    load_o = 1'b0;
    nkind  = KIND_ACK;
    nerr   = ERR_OK;
    nval   = '0;
    nreg   = '0;
    nlast  = 1'b1;
    wr_en  = 1'b0;
    wr_val = '0;
    mem_we = 1'b0;
    sreq   = '0;
    case (st_q)
      ST_IDLE: if (s_axis_tvalid && s_axis_tready) st_d = ST_READ;
      ST_READ: st_d = ST_EXEC;   // memory read data is registered here, for use in ST_EXEC
      ST_EXEC: begin
        if (op_q > OP_MR) begin
          nerr = ERR_BADOP; load_o = 1'b1; st_d = ST_OUT;
        end else if (op_q == OP_FDUMP) begin
          dcnt_d = '0; st_d = ST_DUMP;
        end else if (ri_q > RegIdxW'(NumRegs)) begin
          nerr = ERR_BADREG; load_o = 1'b1; st_d = ST_OUT;
        end else begin
          load_o = 1'b1;
          st_d   = ST_OUT;
          case (op_q)
            OP_SET: begin wr_en = 1'b1; wr_val = imm_q; end
            OP_PUT: begin nkind = KIND_CHAR; nval = {24'd0, rv[7:0]}; end
            OP_LPC: begin wr_en = 1'b1; wr_val = pc_q - 1'b1; end
            OP_ADD: begin wr_en = 1'b1; wr_val = rv + imm_q; end
            OP_SUB: begin wr_en = 1'b1; wr_val = rv - imm_q; end
            OP_MUL, OP_DIV: begin
              if (op_q == OP_DIV && imm_q == '0) nerr = ERR_DIV0;
              else begin
                load_o = 1'b0; st_d = ST_SER;
                sreq.start = 1'b1;
                sreq.op = (op_q == OP_MUL) ? SER_MUL : SER_DIV;
                sreq.a = rv; sreq.b = imm_q;
              end
            end
            OP_DUMP: begin nkind = KIND_DEC; nval = rv; end
            OP_MW:   mem_we = 1'b1;
            default: begin wr_en = 1'b1; wr_val = mrd_q; end
          endcase
        end
      end
      ST_SER: if (srsp.done) begin
        wr_en = 1'b1; wr_val = srsp.res; load_o = 1'b1; st_d = ST_OUT;
      end
      ST_OUT: if (m_axis_tready) st_d = ST_IDLE;
      ST_DUMP: if (!ov_q || m_axis_tready) begin
        load_o = 1'b1;
        nkind  = KIND_DUMP;
        nreg   = dreg;
        nval   = rvalid_q[dreg] ? regs_q[dreg] : '0;
        nlast  = (dcnt_q == RegIdxW'(NumRegs));
        dcnt_d = dcnt_q + 1'b1;
        if (nlast) st_d = ST_OUT;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {3'd0, oreg_q, oval_q};
  assign m_axis_tuser  = {oerr_q, okind_q};
  assign m_axis_tlast  = ol_q;

  `TRM_ASSERT(a_no_in_while_busy, clk_i, rst_ni, (s_axis_tready |-> !ov_q), "input taken while output pending")
  `TRM_ASSERT(a_clear_blocks, clk_i, rst_ni, (clearing |-> !s_axis_tready), "input taken during clearing")
  `TRM_ASSERT(a_hold_stall, clk_i, rst_ni, (ov_q && !m_axis_tready |=> $stable(oval_q)), "stalled word changed")
endmodule

### tb/tb_tiny_register_machine_execute_top.sv
`timescale 1ns / 1ps
module tb_tiny_register_machine_execute_top;
  import trm_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;  // mode, reg_index, mem_address, immediate
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;  // out_value, out_register
  logic [3:0]  m_axis_tuser;  // out_kind, error_code
  logic        m_axis_tlast;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
    logic [4:0]  regno;
    logic        last;
    logic [1:0]  err;
  } word_t;

  word_t       pending_words[$];
  logic [31:0] gen_regs[NumRegs];
  logic [31:0] data_reg_m;
  logic [31:0] mem_m[MemWords];
  logic [31:0] instr_cnt;
  int          fails = 0;
  int          sink_idle_pct = 30;
  int          src_idle_pct = 30;

  tiny_register_machine_execute_top dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [31:0] rd_reg(int r);
    return (r < NumRegs) ? gen_regs[r] : data_reg_m;
  endfunction

  function automatic void wr_reg(int r, logic [31:0] v);
    if (r < NumRegs) gen_regs[r] = v;
    else data_reg_m = v;
  endfunction

  function automatic void push_word(logic [1:0] k, logic [31:0] v, logic [4:0] rn,
                                    logic l, logic [1:0] e);
    word_t w;
    w.kind = k; w.value = v; w.regno = rn; w.last = l; w.err = e;
    pending_words.push_back(w);
  endfunction

  // machine predictor: applies one instruction and queues its output words
  function automatic void execute_instr(logic [3:0] op, logic [4:0] r, logic [8:0] addr,
                                        logic [31:0] imm);
    logic [31:0] pc, a, ma, mb, q;
    pc = instr_cnt;
    instr_cnt = pc + 32'd1;
    if (op > OP_MR) begin
      push_word(KIND_ACK, 32'd0, 5'd0, 1'b1, ERR_BADOP);
      return;
    end
    if (op == OP_FDUMP) begin
      push_word(KIND_DUMP, data_reg_m, 5'(NumRegs), 1'b0, ERR_OK);
      for (int k = 0; k < NumRegs; k++)
        push_word(KIND_DUMP, gen_regs[k], 5'(k), k == NumRegs - 1, ERR_OK);
      return;
    end
    if (r > NumRegs) begin
      push_word(KIND_ACK, 32'd0, 5'd0, 1'b1, ERR_BADREG);
      return;
    end
    a = rd_reg(r);
    case (op)
      OP_SET: wr_reg(r, imm);
      OP_LPC: wr_reg(r, pc);
      OP_ADD: wr_reg(r, a + imm);
      OP_SUB: wr_reg(r, a - imm);
      OP_MUL: wr_reg(r, a * imm);
      OP_DIV: begin
        if (imm == 0) begin
          push_word(KIND_ACK, 32'd0, 5'd0, 1'b1, ERR_DIV0);
          return;
        end
        ma = a[31] ? -a : a;
        mb = imm[31] ? -imm : imm;
        q = ma / mb;
        wr_reg(r, (a[31] != imm[31]) ? -q : q);
      end
      OP_MW:  mem_m[addr] = a;
      OP_MR:  wr_reg(r, mem_m[addr]);
      default: ;
    endcase
    if (op == OP_PUT) push_word(KIND_CHAR, {24'd0, a[7:0]}, 5'd0, 1'b1, ERR_OK);
    else if (op == OP_DUMP) push_word(KIND_DEC, a, 5'd0, 1'b1, ERR_OK);
    else push_word(KIND_ACK, 32'd0, 5'd0, 1'b1, ERR_OK);
  endfunction

  // one word per call; valid drops at the negedge after acceptance
  task automatic send_instr(logic [3:0] op, logic [4:0] r, logic [8:0] addr,
                            logic [31:0] imm);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) @(negedge clk_i);
    s_axis_tdata  <= {6'd0, imm, addr, r, op};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    execute_instr(op, r, addr, imm);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  // sink side: random back-pressure, checks each word against the oldest expectation
  always @(negedge clk_i)
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);

  always @(posedge clk_i) begin
    word_t exp_w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_words.size() == 0) begin
        $error("unexpected output word %h", m_axis_tdata);
        fails++;
      end else begin
        exp_w = pending_words.pop_front();
        if (m_axis_tuser[1:0] !== exp_w.kind) begin
          $error("out_kind exp %0d got %0d", exp_w.kind, m_axis_tuser[1:0]); fails++;
        end
        if (m_axis_tdata[31:0] !== exp_w.value) begin
          $error("out_value exp %h got %h", exp_w.value, m_axis_tdata[31:0]); fails++;
        end
        if (m_axis_tdata[36:32] !== exp_w.regno) begin
          $error("out_register exp %0d got %0d", exp_w.regno, m_axis_tdata[36:32]); fails++;
        end
        if (m_axis_tlast !== exp_w.last) begin
          $error("last exp %0b got %0b", exp_w.last, m_axis_tlast); fails++;
        end
        if (m_axis_tuser[3:2] !== exp_w.err) begin
          $error("error_code exp %0d got %0d", exp_w.err, m_axis_tuser[3:2]); fails++;
        end
      end
    end
  end

  function automatic logic [31:0] rand_imm();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return $urandom_range(9);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    send_instr(OP_FDUMP, 5'd0, 9'd0, 32'd0);
    send_instr(OP_SET, 5'd0, 9'd0, 32'h7fff_ffff);
    send_instr(OP_ADD, 5'd0, 9'd0, 32'd1);
    send_instr(OP_SET, 5'd16, 9'd0, 32'h8000_0000);
    send_instr(OP_DIV, 5'd16, 9'd0, 32'hffff_ffff);
    send_instr(OP_DIV, 5'd16, 9'd0, 32'd0);
    send_instr(OP_SUB, 5'd15, 9'd0, 32'h8000_0000);
    send_instr(OP_MUL, 5'd15, 9'd0, 32'hffff_fffd);
    send_instr(OP_PUT, 5'd15, 9'd0, 32'd0);
    send_instr(OP_DUMP, 5'd16, 9'd0, 32'd0);
    send_instr(OP_LPC, 5'd3, 9'd0, 32'd0);
    send_instr(OP_MW, 5'd3, 9'd511, 32'd0);
    send_instr(OP_MR, 5'd4, 9'd511, 32'd0);
    send_instr(OP_MR, 5'd5, 9'd0, 32'd0);
    send_instr(OP_DUMP, 5'd4, 9'd0, 32'd0);
    send_instr(OP_SET, 5'd17, 9'd0, 32'd5);
    send_instr(OP_DIV, 5'd31, 9'd0, 32'd0);
    send_instr(4'd11, 5'd31, 9'd0, 32'd0);
    send_instr(4'd15, 5'd0, 9'd0, 32'd0);
    send_instr(OP_FDUMP, 5'd31, 9'd0, 32'd0);
    // wait for all words before continuing
    while (pending_words.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_random(int n, int noise_pct);
    logic [3:0] op;
    logic [4:0] r;
    for (int i = 0; i < n; i++) begin
      op = ($urandom_range(99) < noise_pct) ? 4'($urandom_range(15))
           : 4'($urandom_range(OP_MR));
      r  = ($urandom_range(99) < noise_pct) ? 5'($urandom_range(31))
           : 5'($urandom_range(16));
      send_instr(op, r, 9'($urandom_range(511)), rand_imm());
    end
  endtask

  initial begin
    for (int i = 0; i < NumRegs; i++) gen_regs[i] = '0;
    for (int i = 0; i < MemWords; i++) mem_m[i] = '0;
    data_reg_m = '0;
    instr_cnt = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(150, 10);
    src_idle_pct = 0;
    sink_idle_pct = 0;
    test_random(60, 10);
    src_idle_pct = 30;
    sink_idle_pct = 30;
    test_random(130, 25);
    while (pending_words.size() != 0) @(negedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fails == 0) $display("tiny_register_machine_execute_top regression: pass");
    else $display("tiny_register_machine_execute_top regression: fail");
    $finish;
  end

  initial begin
    #5ms;
    $display("tiny_register_machine_execute_top regression: fail");
    $finish;
  end
endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/trm_pkg.sv
hw/rtl/trm_serial_alu.sv
hw/rtl/tiny_register_machine_execute_top.sv
tb/tb_tiny_register_machine_execute_top.sv
